// ===== rtl/core/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the RGB to HSV converter
// Channel widths, fixed-point scales, sector codes and the value lookup table.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int CH_W   = 8;            // one color channel
   localparam int QUO_W  = 13;           // quotient bits out of the divider
   localparam int NUM_W  = CH_W + QUO_W; // dividend width
   localparam int HUE_W  = 15;
   localparam int PCT_W  = 13;

   localparam int HUE_SCALE  = 3840;     // 60 degrees * 64
   localparam int HUE_WRAP   = 23040;    // 360 degrees * 64
   localparam int PCT_SCALE  = 6400;     // 100 percent * 64
   localparam int FULL_SCALE = 255;

   // divider: quotient bits resolved per pipeline stage
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
   // prep (2) + divider + output register
   localparam int PIPE_STAGES = 2 + DIV_STAGES + 1;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // fields that ride alongside the saturation divider
   typedef struct packed {
      sector_type        sector;
      logic              grey;
      logic [PCT_W-1:0]  value;
      logic [CH_W-1:0]   alpha;
   } hsv_side_type;

   typedef logic [PCT_W-1:0] val_tab_type [256];

   function automatic val_tab_type val_tab_build();
      val_tab_type tab;
      for (int i = 0; i < 256; i++) begin
         tab[i] = PCT_W'((i * PCT_SCALE) / FULL_SCALE);
      end
      return tab;
   endfunction

   // value = max * 6400 / 255, indexed by the max channel
   localparam val_tab_type VAL_TAB = val_tab_build();

endpackage

// ===== rtl/core/hsv_prep.sv =====
// ----------------------------------------------------------------------------
// hsv_prep: front two pipeline stages
// Stage 1 finds max, min, span and hue sector; stage 2 forms the dividends
// and looks up value.
// ----------------------------------------------------------------------------
module hsv_prep import hsv_pkg::*; (
   input  logic              clock,
   input  logic [1:0]        en,
   input  logic [CH_W-1:0]   red,
   input  logic [CH_W-1:0]   green,
   input  logic [CH_W-1:0]   blue,
   input  logic [CH_W-1:0]   alpha,
   output logic [NUM_W-1:0]  hue_num,
   output logic [CH_W-1:0]   hue_den,
   output logic              hue_neg,
   output logic [NUM_W-1:0]  sat_num,
   output logic [CH_W-1:0]   sat_den,
   output hsv_side_type      side
);

   // stage 1
   logic [CH_W-1:0]  mx_ff, mx_in;
   logic [CH_W-1:0]  d_ff, d_in;
   logic [CH_W-1:0]  mag_ff, mag_in;
   logic             neg_ff, neg_in;
   sector_type       sector_ff, sector_in;
   logic [CH_W-1:0]  alpha_ff;

   // stage 2
   logic [NUM_W-1:0] hue_num_ff, hue_num_in;
   logic [NUM_W-1:0] sat_num_ff, sat_num_in;
   logic [CH_W-1:0]  hue_den_ff;
   logic [CH_W-1:0]  sat_den_ff;
   logic             hue_neg_ff;
   hsv_side_type     side_ff, side_in;

   logic [CH_W-1:0]  mn;
   logic signed [CH_W:0] num;

   always_comb begin
      mx_in = (red > green) ? red : green;
      if (blue > mx_in) begin
         mx_in = blue;
      end
      mn = (red < green) ? red : green;
      if (blue < mn) begin
         mn = blue;
      end
      d_in = mx_in - mn;

      // blue wins ties over green, green over red
      if (mx_in == blue) begin
         sector_in = SECT_BLUE;
         num       = $signed({1'b0, red}) - $signed({1'b0, green});
      end else if (mx_in == green) begin
         sector_in = SECT_GREEN;
         num       = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_in = SECT_RED;
         num       = $signed({1'b0, green}) - $signed({1'b0, blue});
      end
      neg_in = num[CH_W];
      mag_in = neg_in ? CH_W'(-num) : num[CH_W-1:0];
   end

   always_comb begin
      hue_num_in   = NUM_W'(mag_ff) * NUM_W'(HUE_SCALE);
      sat_num_in   = NUM_W'(d_ff) * NUM_W'(PCT_SCALE);
      side_in.sector = sector_ff;
      side_in.grey   = (d_ff == '0);
      side_in.value  = VAL_TAB[mx_ff];
      side_in.alpha  = alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff     <= mx_in;
         d_ff      <= d_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         sector_ff <= sector_in;
         alpha_ff  <= alpha;
      end
      if (en[1]) begin
         hue_num_ff <= hue_num_in;
         sat_num_ff <= sat_num_in;
         hue_den_ff <= d_ff;
         sat_den_ff <= mx_ff;
         hue_neg_ff <= neg_ff;
         side_ff    <= side_in;
      end
   end

   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign hue_neg = hue_neg_ff;
   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;
   assign side    = side_ff;

endmodule

// ===== rtl/core/hsv_div.sv =====
// ----------------------------------------------------------------------------
// hsv_div: pipelined restoring divider
// Resolves STEP quotient bits per stage; the quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module hsv_div #(
   parameter  int DEN_W  = 8,
   parameter  int Q_W    = 13,
   parameter  int STEP   = 4,
   parameter  int SIDE_W = 1,
   localparam int NUM_W  = DEN_W + Q_W,
   localparam int NST    = (Q_W + STEP - 1) / STEP
) (
   input  logic              clock,
   input  logic [NST-1:0]    en,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_i,
   output logic [Q_W-1:0]    quo,
   output logic [DEN_W-1:0]  rem,
   output logic [SIDE_W-1:0] side_o
);

   logic [DEN_W-1:0]  rem_ff  [NST];
   logic [DEN_W-1:0]  rem_in  [NST];
   logic [Q_W-1:0]    quo_ff  [NST];
   logic [Q_W-1:0]    quo_in  [NST];
   logic [Q_W-1:0]    low_ff  [NST];
   logic [Q_W-1:0]    low_in  [NST];
   logic [DEN_W-1:0]  den_ff  [NST];
   logic [SIDE_W-1:0] side_ff [NST];

   // stage inputs
   logic [DEN_W-1:0]  src_rem  [NST];
   logic [Q_W-1:0]    src_quo  [NST];
   logic [Q_W-1:0]    src_low  [NST];
   logic [DEN_W-1:0]  src_den  [NST];
   logic [SIDE_W-1:0] src_side [NST];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_rem[k]  = num[NUM_W-1:Q_W];
         assign src_low[k]  = num[Q_W-1:0];
         assign src_quo[k]  = '0;
         assign src_den[k]  = den;
         assign src_side[k] = side_i;
      end else begin : g_next
         assign src_rem[k]  = rem_ff[k-1];
         assign src_low[k]  = low_ff[k-1];
         assign src_quo[k]  = quo_ff[k-1];
         assign src_den[k]  = den_ff[k-1];
         assign src_side[k] = side_ff[k-1];
      end

      always_comb begin
         logic [DEN_W-1:0] r;
         logic [Q_W-1:0]   q;
         logic [Q_W-1:0]   lo;
         logic [DEN_W:0]   tr;
         r  = src_rem[k];
         q  = src_quo[k];
         lo = src_low[k];
         tr = '0;
         for (int s = 0; s < STEP; s++) begin
            if (k * STEP + s < Q_W) begin
               tr = {r, lo[Q_W-1]};
               lo = lo << 1;
               if (tr >= {1'b0, src_den[k]}) begin
                  r = DEN_W'(tr - {1'b0, src_den[k]});
                  q = {q[Q_W-2:0], 1'b1};
               end else begin
                  r = tr[DEN_W-1:0];
                  q = {q[Q_W-2:0], 1'b0};
               end
            end
         end
         rem_in[k] = r;
         quo_in[k] = q;
         low_in[k] = lo;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            low_ff[k]  <= low_in[k];
            den_ff[k]  <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign quo    = quo_ff[NST-1];
   assign rem    = rem_ff[NST-1];
   assign side_o = side_ff[NST-1];

endmodule

// ===== rtl/core/hsv_fix.sv =====
// ----------------------------------------------------------------------------
// hsv_fix: output stage
// Adds the sector offset to the hue quotient, applies truncation toward
// zero and the 360 degree wrap, and clears hue/saturation for grey pixels.
// ----------------------------------------------------------------------------
module hsv_fix import hsv_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [QUO_W-1:0]  hue_quo,
   input  logic [CH_W-1:0]   hue_rem,
   input  logic              hue_neg,
   input  logic [QUO_W-1:0]  sat_quo,
   input  hsv_side_type      side,
   output logic [HUE_W-1:0]  hue_q,
   output logic [PCT_W-1:0]  saturation_q,
   output logic [PCT_W-1:0]  value_q,
   output logic [CH_W-1:0]   alpha_out
);

   logic [HUE_W-1:0] hue_ff, hue_in;
   logic [PCT_W-1:0] sat_ff, sat_in;
   logic [PCT_W-1:0] val_ff;
   logic [CH_W-1:0]  alpha_ff;

   logic [HUE_W-1:0] base;
   logic [HUE_W-1:0] qe;

   always_comb begin
      case (side.sector)
         SECT_GREEN: base = HUE_W'(2 * HUE_SCALE);
         SECT_BLUE:  base = HUE_W'(4 * HUE_SCALE);
         default:    base = '0;
      endcase
      qe = HUE_W'(hue_quo);

      if (side.grey) begin
         hue_in = '0;
      end else if (!hue_neg) begin
         hue_in = base + qe;
      end else if (side.sector == SECT_RED) begin
         // small negative quotient truncates to zero, no wrap
         hue_in = (hue_quo == '0) ? '0 : HUE_W'(HUE_WRAP) - qe;
      end else begin
         // positive total: floor of a negative part rounds away
         hue_in = base - qe - HUE_W'(hue_rem != '0);
      end

      sat_in = side.grey ? '0 : sat_quo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         val_ff   <= side.value;
         alpha_ff <= side.alpha;
      end
   end

   assign hue_q        = hue_ff;
   assign saturation_q = sat_ff;
   assign value_q      = val_ff;
   assign alpha_out    = alpha_ff;

endmodule

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: RGBA to HSV plus alpha, fixed point, one pixel/clock unless stalled
// Streams 8-bit RGBA pixels in and hue/saturation/value/alpha responses out.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req_* carries one pixel per request; rsp_* carries one converted pixel
//    per request, in order, one result for every accepted pixel.
//  - Hue is in 1/64 degree (0..23039); saturation and value are percent
//    times 64 (0..6400). Alpha is copied through.
//  - Seven register stages: two prep stages (max/min/sector, then dividend
//    forming and value lookup), four divider stages resolving 4, 4, 4 and 1
//    quotient bits, and one output stage.
//  - Throughput is one pixel per clock while rsp_tready does not stall the
//    output; the hue and saturation dividers are fully pipelined and run side by side.
//  - Every stage has its own valid bit and advances when it is empty or the
//    stage after it advances, so bubbles are squeezed out and req_tready
//    stays high while any stage is free, even when rsp_tready is low.
//  - A stall on rsp_tready holds the occupied stages from the output back to
//    the first empty stage; nothing is dropped or repeated.
//  - Reset clears all valid bits and holds req_tready low; the block is
//    ready as soon as reset is low.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import hsv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // hue_q[14:0], saturation_q[27:15], value_q[40:28],
                                    // alpha_out[48:41], zero fill[55:49]
);

   localparam int PAD_W = 56 - HUE_W - 2 * PCT_W - CH_W;

   // per-stage occupancy and advance enables
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] en;

   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // no request is taken while reset is high
   assign req_tready = en[0] && !reset;
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];

   // prep stages
   logic [NUM_W-1:0] hue_num, sat_num;
   logic [CH_W-1:0]  hue_den, sat_den;
   logic             hue_neg;
   hsv_side_type     side_prep;

   hsv_prep u_prep (
      .clock   (clock),
      .en      (en[1:0]),
      .red     (req_tdata[7:0]),
      .green   (req_tdata[15:8]),
      .blue    (req_tdata[23:16]),
      .alpha   (req_tdata[31:24]),
      .hue_num (hue_num),
      .hue_den (hue_den),
      .hue_neg (hue_neg),
      .sat_num (sat_num),
      .sat_den (sat_den),
      .side    (side_prep)
   );

   // hue divider: |n| * 3840 / span, sign bit rides along
   logic [QUO_W-1:0] hue_quo;
   logic [CH_W-1:0]  hue_rem;
   logic             hue_neg_div;

   hsv_div #(
      .DEN_W  (CH_W),
      .Q_W    (QUO_W),
      .STEP   (DIV_STEP),
      .SIDE_W (1)
   ) u_hue_div (
      .clock  (clock),
      .en     (en[DIV_STAGES+1:2]),
      .num    (hue_num),
      .den    (hue_den),
      .side_i (hue_neg),
      .quo    (hue_quo),
      .rem    (hue_rem),
      .side_o (hue_neg_div)
   );

   // saturation divider: span * 6400 / max, pixel fields ride along
   logic [QUO_W-1:0] sat_quo;
   logic [CH_W-1:0]  sat_rem;
   hsv_side_type     side_div;

   hsv_div #(
      .DEN_W  (CH_W),
      .Q_W    (QUO_W),
      .STEP   (DIV_STEP),
      .SIDE_W ($bits(hsv_side_type))
   ) u_sat_div (
      .clock  (clock),
      .en     (en[DIV_STAGES+1:2]),
      .num    (sat_num),
      .den    (sat_den),
      .side_i (side_prep),
      .quo    (sat_quo),
      .rem    (sat_rem),
      .side_o (side_div)
   );

   // output stage
   logic [HUE_W-1:0] hue_q;
   logic [PCT_W-1:0] saturation_q;
   logic [PCT_W-1:0] value_q;
   logic [CH_W-1:0]  alpha_out;

   hsv_fix u_fix (
      .clock        (clock),
      .en           (en[PIPE_STAGES-1]),
      .hue_quo      (hue_quo),
      .hue_rem      (hue_rem),
      .hue_neg      (hue_neg_div),
      .sat_quo      (sat_quo),
      .side         (side_div),
      .hue_q        (hue_q),
      .saturation_q (saturation_q),
      .value_q      (value_q),
      .alpha_out    (alpha_out)
   );

   assign rsp_tdata = {PAD_W'(0), alpha_out, value_q, saturation_q, hue_q};

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // hue always wrapped below 360 degrees
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue_q < HUE_W'(HUE_WRAP)))
      else $error("hue out of range");

   // saturation and value never exceed 100 percent
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (saturation_q <= PCT_W'(PCT_SCALE) && value_q <= PCT_W'(PCT_SCALE)))
      else $error("saturation or value above full scale");

   // zero saturation only for grey pixels, which carry zero hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && saturation_q == '0) |-> (hue_q == '0))
      else $error("grey pixel with nonzero hue");

   // black pixel must be grey
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && value_q == '0) |-> (saturation_q == '0))
      else $error("black pixel with nonzero saturation");

   // an accepted request occupies the first stage
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted request lost at first stage");

   // a held result keeps the pipeline tail occupied and its data stable
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream-level check of the RGB to HSV converter
// Drives RGBA pixel requests through the req_ stream, predicts each converted
// pixel in fixed point, and compares every rsp_ response against the oldest
// prediction under three sender/receiver idling regimes.
// ----------------------------------------------------------------------------
module tb_top import hsv_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEG60_Q     = 60 * 64;    // hue units per sector
   localparam int DEG360_Q    = 360 * 64;   // full hue circle
   localparam int PCT_Q       = 100 * 64;   // 100 percent
   localparam int CHAN_FULL   = 255;
   localparam int RANDOM_PIX  = 1400;
   localparam int DRAIN_WAIT  = 40;         // well past the pipeline latency
   localparam int CYCLE_LIMIT = 200000;

   // request fields, red in the low byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_pixel_type;

   // response fields, hue in the low bits
   typedef struct packed {
      logic [6:0]  fill;
      logic [7:0]  alpha;
      logic [12:0] value;
      logic [12:0] sat;
      logic [14:0] hue;
   } hsv_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // hue[14:0], sat[27:15], value[40:28], alpha[48:41], fill

   rgba_pixel_type pixel_queue[$];   // pixels waiting to be offered
   hsv_pixel_type  hsv_pending[$];   // predicted conversions, oldest first

   int pixels_total    = 0;
   int pixels_accepted = 0;
   int pixels_checked  = 0;
   int mismatches      = 0;
   int grey_pixels     = 0;
   int tied_pixels     = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 11;
   int recv_idle_pct   = 71;

   rgb_to_hsv_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Fixed-point HSV of one pixel. Sector precedence: blue over green over red
   // when channels tie for the maximum. Division truncates toward zero.
   function automatic hsv_pixel_type hsv_predict(input rgba_pixel_type px);
      hsv_pixel_type res;
      sector_type sect;
      int r, g, b, mx, mn, span, dividend, hue;
      r  = px.red;
      g  = px.green;
      b  = px.blue;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      span = mx - mn;
      res = '0;
      res.alpha = px.alpha;
      res.value = 13'(mx * PCT_Q / CHAN_FULL);
      if (span != 0) begin
         sect = SECT_RED;
         if (mx == g) sect = SECT_GREEN;
         if (mx == b) sect = SECT_BLUE;
         case (sect)
            SECT_RED:   dividend = g - b;
            SECT_GREEN: dividend = 2 * span + b - r;
            default:    dividend = 4 * span + r - g;
         endcase
         hue = dividend * DEG60_Q / span;
         if (hue < 0) hue += DEG360_Q;   // wrap negative red-sector hue
         res.hue = 15'(hue);
         res.sat = 13'(span * PCT_Q / mx);
      end
      return res;
   endfunction

   task automatic queue_pixel(input int r, input int g, input int b, input int a);
      rgba_pixel_type px;
      int mx;
      px = {8'(a), 8'(b), 8'(g), 8'(r)};
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      if (r == g && g == b) grey_pixels++;
      else if ((r == mx) + (g == mx) + (b == mx) > 1) tied_pixels++;
      pixel_queue.push_back(px);
      pixels_total++;
   endtask

   // Driver: offer the next pixel when the slot is free; record the
   // prediction at the edge where the request is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hsv_pending.push_back(hsv_predict(req_tdata));
            pixels_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= pixel_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken response against the oldest prediction,
   // then pick the next cycle's backpressure.
   always @(posedge clock) begin
      hsv_pixel_type got;
      hsv_pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (hsv_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: response with nothing pending: ",
                            "hue %0d sat %0d val %0d a %0d"},
                           got.hue, got.sat, got.value, got.alpha);
            end else begin
               want = hsv_pending.pop_front();
               pixels_checked++;
               if (got.hue != want.hue || got.sat != want.sat ||
                   got.value != want.value || got.alpha != want.alpha ||
                   got.fill != want.fill) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: pixel %0d exp hue %0d sat %0d val %0d a %0d ",
                               "fill %0d, got hue %0d sat %0d val %0d a %0d fill %0d"},
                              pixels_checked, want.hue, want.sat, want.value, want.alpha,
                              want.fill, got.hue, got.sat, got.value, got.alpha,
                              got.fill);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hard stop if the stream hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: timeout after %0d cycles, %0d pixels checked",
               cycle_count, pixels_checked);
      $display("rgb_to_hsv_converter verification failed");
      $finish;
   end

   initial begin
      int kind, r, g, b, lo, hi;

      // directed: extremes, each sector, ties, grey, negative-hue wrap
      queue_pixel(0, 0, 0, 0);         // black
      queue_pixel(255, 255, 255, 255); // white
      queue_pixel(128, 128, 128, 90);  // mid grey
      queue_pixel(255, 0, 0, 255);     // pure red
      queue_pixel(0, 255, 0, 0);       // pure green
      queue_pixel(0, 0, 255, 170);     // pure blue
      queue_pixel(255, 255, 0, 85);    // red/green tie, green formula
      queue_pixel(0, 255, 255, 1);     // green/blue tie, blue formula
      queue_pixel(255, 0, 255, 254);   // red/blue tie, blue formula
      queue_pixel(255, 0, 1, 128);     // red sector, slightly negative: wraps
      queue_pixel(255, 1, 0, 127);     // red sector, just above zero
      queue_pixel(254, 0, 255, 64);    // blue just beats red
      queue_pixel(1, 0, 0, 2);         // smallest nonzero span
      queue_pixel(0, 0, 1, 4);
      queue_pixel(255, 254, 254, 8);   // near grey at full scale
      queue_pixel(200, 100, 150, 16);
      queue_pixel(10, 200, 30, 32);
      queue_pixel(50, 60, 250, 192);
      queue_pixel(100, 255, 254, 224);
      queue_pixel(1, 1, 0, 240);

      // random: mostly arbitrary pixels, plus grey, ties and narrow spans
      for (int i = 0; i < RANDOM_PIX; i++) begin
         kind = $urandom_range(9);
         r = $urandom_range(255);
         g = $urandom_range(255);
         b = $urandom_range(255);
         case (kind)
            0: begin
               g = r;
               b = r;
            end
            1: begin
               hi = $urandom_range(255);
               case ($urandom_range(2))
                  0: begin r = hi; g = hi; b = $urandom_range(hi); end
                  1: begin g = hi; b = hi; r = $urandom_range(hi); end
                  default: begin r = hi; b = hi; g = $urandom_range(hi); end
               endcase
            end
            2: begin
               lo = $urandom_range(250);
               r = lo + $urandom_range(5);
               g = lo + $urandom_range(5);
               b = lo + $urandom_range(5);
            end
            default: ;
         endcase
         queue_pixel(r, g, b, $urandom_range(255));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // idling regimes: slow receiver, then slow sender, then none
      wait (pixels_accepted >= pixels_total / 3);
      send_idle_pct = 71;
      recv_idle_pct = 11;
      wait (pixels_accepted >= 2 * pixels_total / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;

      wait (pixels_accepted == pixels_total && hsv_pending.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Checked %0d of %0d pixels (%0d grey, %0d with a tied maximum)",
               pixels_checked, pixels_total, grey_pixels, tied_pixels);
      $display("Idling regimes covered: slow receiver, slow sender, full rate; %0d mismatches",
               mismatches);
      if (mismatches == 0 && hsv_pending.size() == 0) begin
         $display("rgb_to_hsv_converter verification clean");
      end else begin
         $display("rgb_to_hsv_converter verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/hsv_pkg.sv
rtl/core/hsv_prep.sv
rtl/core/hsv_div.sv
rtl/core/hsv_fix.sv
rtl/core/rgb_to_hsv_converter.sv
bench/tb_top.sv
